// ===== sv/bllca_pkg.sv =====
`timescale 1ns / 1ps

package bllca_pkg;

    localparam int NODE_W = 10;
    localparam int MODE_W = 2;
    localparam int STEP_W = 10;
    localparam int BIT_W  = 4;
    localparam int RECIP_SHIFT = 2 * NODE_W;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LCA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KTH  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] parent_node;
        logic [NODE_W-1:0] node_depth;
        logic [STEP_W-1:0] steps;
    } req_word_t;

    typedef struct packed {
        logic [NODE_W-1:0] answer_node;
        logic              found;
    } rsp_word_t;

endpackage

// ===== sv/binary_lifting_lca.sv =====
`timescale 1ns / 1ps

// Binary lifting ancestor engine for a rooted forest.
// Request channel (req_valid/req_stall/req_word): one word per load or query.
// A load gives node, parent (itself for a root) and depth; parents load first.
// An LCA query gives node_a and node_b; a k-th ancestor query node_a and steps.
// Response channel (rsp_valid/rsp_stall/rsp_word): one word per query, none
// per load or for the unused mode code.
// One item is worked at a time; req_stall is high from acceptance until the
// sequencer is back in idle. Every table access goes through registered-read
// jump-row and depth memories (two read ports, one write port), so the cost
// is set by the number of hops. A load builds its row one level per hop.
// A k-th query climbs once per set bit of steps, repeating the top level
// for a set bit that lies above it, and answers at once, not found, if
// steps exceed the depth. An LCA query lifts the deeper node by the depth
// gap, descends from the top level, and takes a final parent step unless
// the lifted nodes already meet.
// A finished answer sits in the response register; while rsp_stall is high
// the next request is still taken and worked, and its answer waits until the
// register frees. Reset clears the sequencer and rsp_valid; table contents
// are undefined until loaded.
module binary_lifting_lca #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  bllca_pkg::req_word_t req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output bllca_pkg::rsp_word_t rsp_word
);

    localparam int NW = bllca_pkg::NODE_W;
    localparam int SW = $clog2(MAX_NODES);
    localparam int LW = $clog2(JUMP_LEVELS + 1);
    localparam int BW = bllca_pkg::BIT_W;
    localparam int KW = bllca_pkg::STEP_W;

    typedef logic [JUMP_LEVELS:0][NW-1:0] jrow_t;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_L_ISSUE = 4'd1;
    localparam logic [3:0] ST_L_USE   = 4'd2;
    localparam logic [3:0] ST_L_WRITE = 4'd3;
    localparam logic [3:0] ST_Q_ISSUE = 4'd4;
    localparam logic [3:0] ST_Q_DEPTH = 4'd5;
    localparam logic [3:0] ST_C_ISSUE = 4'd6;
    localparam logic [3:0] ST_C_USE   = 4'd7;
    localparam logic [3:0] ST_D_ISSUE = 4'd8;
    localparam logic [3:0] ST_D_USE   = 4'd9;
    localparam logic [3:0] ST_F_ISSUE = 4'd10;
    localparam logic [3:0] ST_F_USE   = 4'd11;
    localparam logic [3:0] ST_OUT     = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    bllca_pkg::rsp_word_t rsp_word_reg, rsp_word_next;
    bllca_pkg::rsp_word_t res_reg, res_next;

    logic [bllca_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [NW-1:0] na_reg, na_next;
    logic [NW-1:0] nb_reg, nb_next;
    logic [NW-1:0] dep_reg, dep_next;
    logic [KW-1:0] kk_reg, kk_next;
    logic [KW-1:0] rep_reg, rep_next;
    logic [BW-1:0] cb_reg, cb_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic          self_reg, self_next;
    jrow_t         row_reg, row_next;

    logic [SW-1:0] slot_a, slot_b;

    jrow_t         jump_mem [MAX_NODES];
    logic [NW-1:0] depth_mem [MAX_NODES];
    jrow_t         rd_jump_a, rd_jump_b;
    logic [NW-1:0] rd_depth_a, rd_depth_b;
    logic          wr_en;

    // node index to table slot (index modulo MAX_NODES)
    generate
        if (MAX_NODES >= (1 << NW)) begin : g_slot_direct
            assign slot_a = SW'(na_reg);
            assign slot_b = SW'(nb_reg);
        end else begin : g_slot_recip
            localparam int RECIP = (1 << bllca_pkg::RECIP_SHIFT) / MAX_NODES;
            localparam int PW = bllca_pkg::RECIP_SHIFT + NW;
            logic [PW-1:0] prod_a, prod_b;
            logic [NW-1:0] q_a_reg, q_b_reg;
            logic [2*NW-1:0] qm_a, qm_b;
            logic [NW:0] r_a, r_b, s_a, s_b;

            assign prod_a = PW'(na_next) * PW'(RECIP);
            assign prod_b = PW'(nb_next) * PW'(RECIP);

            always_ff @(posedge clk)
            begin
                q_a_reg <= prod_a[PW-1:bllca_pkg::RECIP_SHIFT];
                q_b_reg <= prod_b[PW-1:bllca_pkg::RECIP_SHIFT];
            end

            // quotient estimate is exact or one low: one correction step
            assign qm_a = (2*NW)'(q_a_reg) * (2*NW)'(MAX_NODES);
            assign qm_b = (2*NW)'(q_b_reg) * (2*NW)'(MAX_NODES);
            assign r_a  = (NW+1)'(na_reg) - qm_a[NW:0];
            assign r_b  = (NW+1)'(nb_reg) - qm_b[NW:0];
            assign s_a  = (r_a >= (NW+1)'(MAX_NODES)) ? r_a - (NW+1)'(MAX_NODES) : r_a;
            assign s_b  = (r_b >= (NW+1)'(MAX_NODES)) ? r_b - (NW+1)'(MAX_NODES) : r_b;
            assign slot_a = SW'(s_a);
            assign slot_b = SW'(s_b);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            jump_mem[slot_b]  <= row_reg;
            depth_mem[slot_b] <= dep_reg;
        end
        rd_jump_a  <= jump_mem[slot_a];
        rd_jump_b  <= jump_mem[slot_b];
        rd_depth_a <= depth_mem[slot_a];
        rd_depth_b <= depth_mem[slot_b];
    end

    logic [LW-1:0] climb_lvl;
    logic [4:0]    rep_sh;
    logic          rep_last;
    logic [NW-1:0] load_val;
    logic [NW-1:0] ha, hb;

    always_comb
    begin
        climb_lvl = (int'(cb_reg) <= JUMP_LEVELS) ? LW'(cb_reg) : LW'(JUMP_LEVELS);
        rep_sh    = 5'(cb_reg) - 5'(JUMP_LEVELS);
        rep_last  = (int'(cb_reg) <= JUMP_LEVELS) ||
                    (rep_reg == ((KW'(1) << rep_sh) - KW'(1)));
        load_val  = self_reg ? row_reg[lvl_reg - LW'(1)] : rd_jump_a[lvl_reg - LW'(1)];
        ha        = rd_jump_a[lvl_reg];
        hb        = rd_jump_b[lvl_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        res_next       = res_reg;
        mode_next      = mode_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        dep_next       = dep_reg;
        kk_next        = kk_reg;
        rep_next       = rep_reg;
        cb_next        = cb_reg;
        lvl_next       = lvl_reg;
        self_next      = self_reg;
        row_next       = row_reg;
        wr_en          = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next = req_word.mode;
                    na_next   = req_word.node_a;
                    nb_next   = req_word.node_b;
                    kk_next   = req_word.steps;
                    case (req_word.mode)
                        bllca_pkg::MODE_LOAD:
                        begin
                            row_next[0] = req_word.parent_node;
                            dep_next    = req_word.node_depth;
                            na_next     = req_word.parent_node;
                            nb_next     = req_word.node_a;
                            lvl_next    = LW'(1);
                            state_next  = ST_L_ISSUE;
                        end
                        bllca_pkg::MODE_LCA,
                        bllca_pkg::MODE_KTH:
                        begin
                            state_next = ST_Q_ISSUE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_L_ISSUE:
            begin
                // ancestor row may be the row under construction
                self_next  = (slot_a == slot_b);
                state_next = ST_L_USE;
            end

            ST_L_USE:
            begin
                row_next[lvl_reg] = load_val;
                na_next           = load_val;
                if (lvl_reg == LW'(JUMP_LEVELS))
                begin
                    state_next = ST_L_WRITE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = ST_L_ISSUE;
                end
            end

            ST_L_WRITE:
            begin
                wr_en      = 1'b1;
                state_next = ST_IDLE;
            end

            ST_Q_ISSUE:
            begin
                state_next = ST_Q_DEPTH;
            end

            ST_Q_DEPTH:
            begin
                cb_next  = '0;
                rep_next = '0;
                if (mode_reg == bllca_pkg::MODE_KTH)
                begin
                    if (kk_reg > rd_depth_a)
                    begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_C_ISSUE;
                    end
                end
                else
                begin
                    if (rd_depth_a < rd_depth_b)
                    begin
                        na_next = nb_reg;
                        nb_next = na_reg;
                        kk_next = rd_depth_b - rd_depth_a;
                    end
                    else
                    begin
                        kk_next = rd_depth_a - rd_depth_b;
                    end
                    state_next = ST_C_ISSUE;
                end
            end

            ST_C_ISSUE:
            begin
                if (cb_reg == BW'(KW))
                begin
                    if (mode_reg == bllca_pkg::MODE_KTH || na_reg == nb_reg)
                    begin
                        res_next.answer_node = na_reg;
                        res_next.found       = 1'b1;
                        state_next           = ST_OUT;
                    end
                    else
                    begin
                        lvl_next   = LW'(JUMP_LEVELS);
                        state_next = ST_D_ISSUE;
                    end
                end
                else if (!kk_reg[cb_reg])
                begin
                    cb_next = cb_reg + BW'(1);
                end
                else
                begin
                    state_next = ST_C_USE;
                end
            end

            ST_C_USE:
            begin
                na_next = rd_jump_a[climb_lvl];
                if (rep_last)
                begin
                    cb_next  = cb_reg + BW'(1);
                    rep_next = '0;
                end
                else
                begin
                    rep_next = rep_reg + KW'(1);
                end
                state_next = ST_C_ISSUE;
            end

            ST_D_ISSUE:
            begin
                state_next = ST_D_USE;
            end

            ST_D_USE:
            begin
                if (ha != hb)
                begin
                    na_next = ha;
                    nb_next = hb;
                end
                if (lvl_reg == '0)
                begin
                    state_next = ST_F_ISSUE;
                end
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = ST_D_ISSUE;
                end
            end

            ST_F_ISSUE:
            begin
                state_next = ST_F_USE;
            end

            ST_F_USE:
            begin
                if (rd_jump_a[0] != rd_jump_b[0])
                begin
                    res_next = '0;
                end
                else
                begin
                    res_next.answer_node = rd_jump_a[0];
                    res_next.found       = 1'b1;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
        res_reg      <= res_next;
        mode_reg     <= mode_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        dep_reg      <= dep_next;
        kk_reg       <= kk_next;
        rep_reg      <= rep_next;
        cb_reg       <= cb_next;
        lvl_reg      <= lvl_next;
        self_reg     <= self_next;
        row_reg      <= row_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
